@@ hw/rtl/tlpa_pkg.sv @@
// Shared types and constants for the two-level page allocator.
// No dependencies; imported by every allocator module.
package tlpa_pkg;
    localparam int DIRS     = 1024;
    localparam int PAGES    = 1024;
    localparam int WORD_W   = 64;
    localparam int WORDS    = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W   = $clog2(WORDS);
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int PAGE_W   = $clog2(PAGES);
    localparam int DIR_W    = $clog2(DIRS);
    localparam int CNT_W    = DIR_W + 1;
    localparam int LIM_W    = 11;
    localparam int FRAME_W  = 20;
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1024);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        K_NONE,
        K_PAGE,
        K_NEWDIR
    } t_kind;

    typedef struct packed {
        logic  start_scan;
        logic  probe;
        logic  load_result;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic can_scan;
        logic can_create;
        logic hit;
        logic last_word;
    } t_status;
endpackage

@@ hw/rtl/tlpa_ctrl.sv @@
// Sequencer for the page allocator: handshakes and word scan control.
// Depends on tlpa_pkg.
module tlpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req,
    output logic            o_req_ready,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    input  tlpa_pkg::t_status i_status,
    output tlpa_pkg::t_cmd  o_cmd
);
    import tlpa_pkg::*;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= K_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        o_req_ready = 1'b0;
        o_cmd       = '{start_scan: 1'b0, probe: 1'b0, load_result: 1'b0, kind: r_kind};
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    priority if (!i_req) begin
                        n_kind  = K_NONE;
                        n_state = ST_DONE;
                    end else if (i_status.can_scan) begin
                        o_cmd.start_scan = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        n_kind  = i_status.can_create ? K_NEWDIR : K_NONE;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.probe = 1'b1;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                priority if (i_status.hit) begin
                    n_kind  = K_PAGE;
                    n_state = ST_DONE;
                end else if (i_status.last_word) begin
                    n_kind  = i_status.can_create ? K_NEWDIR : K_NONE;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.load_result ? 1'b1 : (i_res_ready ? 1'b0 : r_out_valid);
    end

    assign o_res_valid = r_out_valid;

    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_result |-> (r_state == ST_DONE))
        else $error("result load outside done state");
    a_page_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && i_status.hit) |=> (r_kind == K_PAGE))
        else $error("hit not recorded as page");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_req_ready)
        else $error("ready while busy");
endmodule

@@ hw/rtl/tlpa_datapath.sv @@
// Datapath: directory count, limit register, bitmap of the open directory,
// word probe and result registers. Depends on tlpa_pkg.
module tlpa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tlpa_pkg::LIM_W-1:0]    i_cfg_data,
    input  tlpa_pkg::t_cmd                i_cmd,
    output tlpa_pkg::t_status             o_status,
    output logic [tlpa_pkg::FRAME_W-1:0]  o_frame,
    output logic                          o_found,
    output logic                          o_new_dir
);
    import tlpa_pkg::*;

    // Directories below the count are present; all but the newest are full.
    logic [CNT_W-1:0]   r_dir_count;
    logic [LIM_W-1:0]   r_dir_limit;
    logic [WORD_W-1:0]  r_words [WORDS];
    logic [WIDX_W-1:0]  r_word_idx;
    logic [WIDX_W-1:0]  r_hit_idx;
    logic [BIT_W-1:0]   r_bit;
    logic               r_hit;
    logic [FRAME_W-1:0] r_frame;
    logic               r_found;
    logic               r_new_dir;

    logic [CNT_W-1:0]   eff_lim;
    logic [WORD_W-1:0]  cur_word;
    logic [BIT_W-1:0]   low_zero;
    logic [DIR_W-1:0]   last_dir;

    assign eff_lim  = (r_dir_limit > LIM_W'(DIRS)) ? CNT_W'(DIRS) : CNT_W'(r_dir_limit);
    assign cur_word = r_words[r_word_idx];
    assign last_dir = DIR_W'(r_dir_count - CNT_W'(1));

    always_comb begin
        low_zero = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!cur_word[i]) low_zero = BIT_W'(i);
        end
    end

    assign o_status.can_scan   = (r_dir_count != '0) && (r_dir_count <= eff_lim);
    assign o_status.can_create = r_dir_count < eff_lim;
    assign o_status.hit        = r_hit;
    assign o_status.last_word  = r_hit_idx == WIDX_W'(WORDS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_count <= '0;
            r_dir_limit <= LIMIT_RESET;
        end else begin
            if (i_cfg_we) r_dir_limit <= i_cfg_data;
            if (i_cmd.load_result && i_cmd.kind == K_NEWDIR)
                r_dir_count <= r_dir_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) r_word_idx <= '0;
        if (i_cmd.probe) begin
            r_hit      <= ~&cur_word;
            r_bit      <= low_zero;
            r_hit_idx  <= r_word_idx;
            r_word_idx <= r_word_idx + WIDX_W'(1);
        end
        if (i_cmd.load_result) begin
            unique case (i_cmd.kind)
                K_PAGE: begin
                    r_words[r_hit_idx][r_bit] <= 1'b1;
                    r_frame   <= FRAME_W'({last_dir, r_hit_idx, r_bit});
                    r_found   <= 1'b1;
                    r_new_dir <= 1'b0;
                end
                K_NEWDIR: begin
                    // pages 0 and 1 taken, the rest free
                    for (int w = 0; w < WORDS; w++)
                        r_words[w] <= (w == 0) ? WORD_W'(3) : '0;
                    r_frame   <= FRAME_W'({r_dir_count[DIR_W-1:0], PAGE_W'(1)});
                    r_found   <= 1'b1;
                    r_new_dir <= 1'b1;
                end
                default: begin
                    r_frame   <= '0;
                    r_found   <= 1'b0;
                    r_new_dir <= 1'b0;
                end
            endcase
        end
    end

    assign o_frame   = r_frame;
    assign o_found   = r_found;
    assign o_new_dir = r_new_dir;

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir_count <= CNT_W'(DIRS))
        else $error("directory count overflow");
    a_page_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_result && i_cmd.kind == K_PAGE) |-> r_hit)
        else $error("page result without free bit");
    a_newdir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_result && i_cmd.kind == K_NEWDIR) |=> (r_words[0] == WORD_W'(3)))
        else $error("new directory bitmap not initialized");
endmodule

@@ hw/rtl/two_level_page_allocator.sv @@
// Top level of the two-level first-fit page allocator.
// Depends on tlpa_pkg, tlpa_ctrl and tlpa_datapath.
//
// One request is handled at a time. A no-op, or a request that needs no scan,
// goes from idle straight to the done state; a request that scans the open directory probes
// its 16 bitmap words one at a time through the scan and eval states. Only the
// newest directory can hold free pages, so its bitmap is the only one kept.
// The result register frees the next request while an old result waits.
module two_level_page_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tlpa_pkg::LIM_W-1:0] i_cfg_data,   // dir_limit
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,    // [0] request
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [23:0]                o_m_tdata,    // [19:0] page_frame
    output logic [1:0]                 o_m_tuser     // [0] found, [1] new_directory
);
    import tlpa_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic [FRAME_W-1:0] frame;
    logic               found;
    logic               new_dir;

    assign o_cfg_ready = 1'b1;

    tlpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .i_req       (i_s_tdata[0]),
        .o_req_ready (o_s_tready),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tlpa_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_frame    (frame),
        .o_found    (found),
        .o_new_dir  (new_dir)
    );

    assign o_m_tdata = {4'b0, frame};
    assign o_m_tuser = {new_dir, found};
endmodule

@@ verif/tb.sv @@
// Testbench for two_level_page_allocator: drives page requests and dir_limit writes,
// predicts every frame with an internal first-fit model and checks each result transfer.
// Depends on tlpa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;
    import tlpa_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               found;
        logic               newdir;
    } t_alloc;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [LIM_W-1:0]   i_cfg_data = '0;
    logic               i_s_tvalid = 1'b0;
    logic [7:0]         i_s_tdata = '0;
    logic               i_m_tready = 1'b0;
    logic               o_cfg_ready, o_s_tready, o_m_tvalid;
    logic [23:0]        o_m_tdata;
    logic [1:0]         o_m_tuser;

    two_level_page_allocator dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bit              present [DIRS];
    bit              full [DIRS];
    bit [PAGES-1:0]  used [DIRS];
    int unsigned     limit_q = 1024;

    logic [7:0]      req_q [$];
    t_alloc          alloc_q [$];
    int              errors = 0;
    int              burst = 0, gap = 0, stall_ph = 0;
    bit              s_taken = 1'b0;

    function automatic t_alloc predict_alloc(logic [7:0] req);
        t_alloc r;
        int lim;
        r = '0;
        if (!req[0]) return r;
        lim = (limit_q > DIRS) ? DIRS : limit_q;
        for (int d = 0; d < lim; d++) begin
            if (full[d]) continue;
            if (present[d]) begin
                for (int p = 0; p < PAGES; p++) begin
                    if (!used[d][p]) begin
                        used[d][p] = 1'b1;
                        r.frame = FRAME_W'(d * PAGES + p);
                        r.found = 1'b1;
                        return r;
                    end
                end
                continue;
            end
            if (d > 0) full[d-1] = 1'b1;
            present[d] = 1'b1;
            used[d] = '0;
            used[d][1:0] = 2'b11;
            r.frame = FRAME_W'(d * PAGES + 1);
            r.found = 1'b1;
            r.newdir = 1'b1;
            return r;
        end
        return r;
    endfunction

    // sender: bursts and gaps
    always @(negedge i_clk) begin
        if (i_s_tvalid && !s_taken) begin
        end else if (gap > 0) begin
            gap <= gap - 1;
            i_s_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata <= req_q[0];
            if (burst <= 1) begin
                burst <= $urandom_range(1, 12);
                gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end else
                burst <= burst - 1;
        end else
            i_s_tvalid <= 1'b0;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        stall_ph <= stall_ph + 1;
        if (stall_ph[8]) i_m_tready <= 1'b1;
        else i_m_tready <= ($urandom_range(0, 3) != 0) && !(stall_ph[4:2] == 3'd5);
    end

    always @(posedge i_clk) begin
        t_alloc e;
        s_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            alloc_q.push_back(predict_alloc(req_q[0]));
            void'(req_q.pop_front());
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (alloc_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = alloc_q.pop_front();
                if (o_m_tdata[FRAME_W-1:0] !== e.frame) begin
                    $error("page_frame exp %0d got %0d", e.frame, o_m_tdata[FRAME_W-1:0]);
                    errors++;
                end
                if (o_m_tuser[0] !== e.found) begin
                    $error("found exp %0b got %0b", e.found, o_m_tuser[0]);
                    errors++;
                end
                if (o_m_tuser[1] !== e.newdir) begin
                    $error("new_directory exp %0b got %0b", e.newdir, o_m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (req_q.size() > 0 || i_s_tvalid || alloc_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_limit(int unsigned v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= LIM_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_q = v & 11'h7FF;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_reqs(int n, int pct);
        for (int i = 0; i < n; i++) begin
            req_q.push_back({7'($urandom_range(0, 127)),
                             ($urandom_range(0, 99) < pct) ? 1'b1 : 1'b0});
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: limit 1 with no-ops and page requests in dir 0, then limit 0 so requests fail
        set_limit(1);
        req_q.push_back(8'h00);
        req_q.push_back(8'hFE);
        req_q.push_back(8'h01);
        req_q.push_back(8'hFF);
        req_q.push_back(8'h01);
        drain();
        set_limit(0);
        req_q.push_back(8'h01);
        req_q.push_back(8'h55);
        drain();
        set_limit(2047);
        push_reqs(12, 100);
        drain();
        // random: small limits, then 1024, with mostly page requests
        set_limit(2);
        push_reqs(250, 90);
        drain();
        set_limit(1);
        push_reqs(20, 80);
        drain();
        set_limit(3);
        push_reqs(300, 95);
        drain();
        set_limit(1024);
        push_reqs(40, 70);
        drain();
        if (errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: errors");
        $finish;
    end
endmodule
